[sv/swl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swl_pkg;

    // Fixed field widths
    localparam int ARRIVAL_W = 32;
    localparam int RATE_W    = 11;
    localparam int WINDOW_W  = 32;
    localparam int SERVERS_W = 9;
    localparam int INDEX_W   = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 2'd2;

    // Register reset values
    localparam logic [RATE_W-1:0]    RST_MAX_RATE     = 11'd1024;
    localparam logic [WINDOW_W-1:0]  RST_WINDOW_TICKS = 32'd1000000;
    localparam logic [SERVERS_W-1:0] RST_SERVER_COUNT = 9'd1;

    // Microprogram step address
    typedef logic [0:0] step_t;
    localparam step_t STEP_WAIT = 1'b0;
    localparam step_t STEP_SCAN = 1'b1;

    typedef enum logic [0:0] {
        COND_IN_VALID = 1'b0,
        COND_EXPIRE   = 1'b1
    } cond_sel_t;

    // Datapath actions, at most one per cycle
    typedef struct packed {
        logic latch;
        logic pop;
        logic emit;
    } act_t;

    localparam act_t ACT_NONE  = '{latch: 1'b0, pop: 1'b0, emit: 1'b0};
    localparam act_t ACT_LATCH = '{latch: 1'b1, pop: 1'b0, emit: 1'b0};
    localparam act_t ACT_POP   = '{latch: 1'b0, pop: 1'b1, emit: 1'b0};
    localparam act_t ACT_EMIT  = '{latch: 1'b0, pop: 1'b0, emit: 1'b1};

    typedef struct packed {
        cond_sel_t cond;
        logic      take_in;
        act_t      act_hit;
        step_t     next_hit;
        act_t      act_miss;
        step_t     next_miss;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic expire;
        logic out_free;
    } cond_t;

    typedef struct packed {
        logic expire;
        logic out_free;
    } dp_status_t;

    // Control store
    function automatic uword_t ucode_rom(input step_t step);
        uword_t w;
        unique case (step)
            STEP_WAIT: begin
                w = '{cond: COND_IN_VALID, take_in: 1'b1,
                      act_hit: ACT_LATCH, next_hit: STEP_SCAN,
                      act_miss: ACT_NONE, next_miss: STEP_WAIT};
            end
            STEP_SCAN: begin
                w = '{cond: COND_EXPIRE, take_in: 1'b0,
                      act_hit: ACT_POP, next_hit: STEP_SCAN,
                      act_miss: ACT_EMIT, next_miss: STEP_WAIT};
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/swl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module swl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/swl_useq.sv]
`timescale 1ns / 1ps
`default_nettype none

module swl_useq
    import swl_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cond_t cond,
    output logic       s_ready,
    output act_t       act
);

    step_t  step_reg;
    step_t  step_next;
    uword_t uw;
    logic   hit;
    act_t   act_sel;
    step_t  step_sel;
    logic   stall;

    always_comb begin
        uw = ucode_rom(step_reg);
        unique case (uw.cond)
            COND_IN_VALID: hit = cond.in_valid;
            COND_EXPIRE:   hit = cond.expire;
        endcase
        act_sel  = hit ? uw.act_hit : uw.act_miss;
        step_sel = hit ? uw.next_hit : uw.next_miss;
        // result register still occupied: hold this step
        stall     = act_sel.emit && !cond.out_free;
        act       = stall ? ACT_NONE : act_sel;
        step_next = stall ? step_reg : step_sel;
        s_ready   = uw.take_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

[sv/swl_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none

module swl_dpath
    import swl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 1024,
    parameter int MAX_SERVERS = 256,
    parameter int TIME_WIDTH  = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [ARRIVAL_W-1:0] s_arrival_time,
    input  wire act_t                 act,
    input  wire logic                 m_ready,
    output dp_status_t                status,
    output logic                      m_valid,
    output logic                      m_admitted,
    output logic [INDEX_W-1:0]        m_server_index
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int LIM_W  = (CNT_W > RATE_W) ? CNT_W : RATE_W;
    localparam int SRV_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int SCW    = $clog2(MAX_SERVERS + 1);
    localparam int SCNT_W = (SCW > SERVERS_W) ? SCW : SERVERS_W;
    localparam int CMP_W  = (TIME_WIDTH > WINDOW_W) ? TIME_WIDTH : WINDOW_W;
    localparam int ARR_W  = TIME_WIDTH + ARRIVAL_W;

    logic [RATE_W-1:0]     max_rate_reg;
    logic [WINDOW_W-1:0]   window_reg;
    logic [SERVERS_W-1:0]  server_count_reg;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SRV_W-1:0]      next_server_reg, next_server_next;
    logic [TIME_WIDTH-1:0] now_reg;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_admitted_reg;
    logic [INDEX_W-1:0]    m_server_index_reg;

    logic [ARR_W-1:0]      arr_ext;
    logic [PTR_W-1:0]      head_inc;
    logic [SUM_W-1:0]      tail_sum, tail_wrap;
    logic [PTR_W-1:0]      tail;
    logic [TIME_WIDTH-1:0] rd_data;
    logic [TIME_WIDTH-1:0] age;
    logic [LIM_W-1:0]      rate_ext, limit;
    logic                  full;
    logic [SCNT_W-1:0]     sc_ext, servers_eff, ns_ext, chosen, chosen_inc, rr_wrap;
    logic                  push;

    always_comb begin
        arr_ext  = ARR_W'(s_arrival_time);
        head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);

        tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
        tail_wrap = tail_sum - SUM_W'(QUEUE_DEPTH);
        tail = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_wrap[PTR_W-1:0]
                                                  : tail_sum[PTR_W-1:0];

        // modular age; a late stamp looks very old and expires
        age = now_reg - rd_data;
        status.expire   = (count_reg != '0) && (CMP_W'(age) >= CMP_W'(window_reg));
        status.out_free = !m_valid_reg || m_ready;

        rate_ext = LIM_W'(max_rate_reg);
        limit    = (rate_ext > LIM_W'(QUEUE_DEPTH)) ? LIM_W'(QUEUE_DEPTH) : rate_ext;
        full     = LIM_W'(count_reg) >= limit;
        push     = act.emit && !full;

        sc_ext = SCNT_W'(server_count_reg);
        if (sc_ext == '0) begin
            servers_eff = SCNT_W'(1);
        end else if (sc_ext > SCNT_W'(MAX_SERVERS)) begin
            servers_eff = SCNT_W'(MAX_SERVERS);
        end else begin
            servers_eff = sc_ext;
        end
        ns_ext     = SCNT_W'(next_server_reg);
        chosen     = (ns_ext < servers_eff) ? ns_ext : '0;
        chosen_inc = chosen + SCNT_W'(1);
        rr_wrap    = (chosen_inc >= servers_eff) ? '0 : chosen_inc;

        head_next        = head_reg;
        count_next       = count_reg;
        next_server_next = next_server_reg;
        if (act.pop) begin
            head_next  = head_inc;
            count_next = count_reg - CNT_W'(1);
        end
        if (push) begin
            count_next       = count_reg + CNT_W'(1);
            next_server_next = rr_wrap[SRV_W-1:0];
        end

        if (act.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    swl_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_stamp_ram (
        .aclk  (aclk),
        .we    (push),
        .waddr (tail),
        .wdata (now_reg),
        .raddr (act.pop ? head_inc : head_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_rate_reg     <= RST_MAX_RATE;
            window_reg       <= RST_WINDOW_TICKS;
            server_count_reg <= RST_SERVER_COUNT;
            head_reg         <= '0;
            count_reg        <= '0;
            next_server_reg  <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MAX_RATE:     max_rate_reg     <= cfg_data[RATE_W-1:0];
                    CFG_WINDOW_TICKS: window_reg       <= cfg_data[WINDOW_W-1:0];
                    CFG_SERVER_COUNT: server_count_reg <= cfg_data[SERVERS_W-1:0];
                    default: ;
                endcase
            end
            head_reg        <= head_next;
            count_reg       <= count_next;
            next_server_reg <= next_server_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (act.latch) begin
            now_reg <= arr_ext[TIME_WIDTH-1:0];
        end
        if (act.emit) begin
            m_admitted_reg     <= !full;
            m_server_index_reg <= full ? '0 : chosen[INDEX_W-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_admitted     = m_admitted_reg;
    assign m_server_index = m_server_index_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        act.pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        act.emit |=> m_valid_reg)
        else $error("emitted item not presented");

    a_drop_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_admitted_reg) |-> m_server_index_reg == '0)
        else $error("dropped item carries a server index");

endmodule

`default_nettype wire

[sv/sliding_window_limiter_round_robin.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Ports                                 | Handshake
// --------+---------------------------------------+------------------------
// input   | s_arrival_time                        | s_valid / s_ready
// result  | m_admitted, m_server_index            | m_valid / m_ready
// config  | cfg_index, cfg_data                   | cfg_we, no wait
//
// An item is latched, then the stored stamps that expire on its arrival are
// popped, one stamp a cycle through the single read port of the stamp memory,
// and then the item is decided.
// Reset is synchronous, active low; the stamp memory needs no clearing pass.
// The next item is taken while a result waits; the scan then holds at its
// decision step until the result register is free.

module sliding_window_limiter_round_robin
    import swl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 1024,
    parameter int MAX_SERVERS = 256,
    parameter int TIME_WIDTH  = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration writes
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // request arrivals
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [ARRIVAL_W-1:0] s_arrival_time,
    // admission results
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_admitted,
    output logic [INDEX_W-1:0]        m_server_index
);

    cond_t      cond;
    act_t       act;
    dp_status_t status;

    // Sequencer conditions: an arrival is waiting, the oldest stamp is
    // expired, the result register can take a new item.
    assign cond = '{in_valid: s_valid, expire: status.expire, out_free: status.out_free};

    // Two-step microprogram: wait for an item, then scan-and-pop the oldest
    // stamps until one is inside the window or none is left, then decide and emit.
    swl_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .s_ready (s_ready),
        .act     (act)
    );

    // Stamp FIFO, rate check, round-robin pointer and result register.
    swl_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_SERVERS (MAX_SERVERS),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_arrival_time (s_arrival_time),
        .act            (act),
        .m_ready        (m_ready),
        .status         (status),
        .m_valid        (m_valid),
        .m_admitted     (m_admitted),
        .m_server_index (m_server_index)
    );

endmodule

`default_nettype wire
